// ===== hdl/ppfc_pkg.sv =====
// Shared types and constants for the pulse period and frequency counter.
// No dependencies; used by the divider, the top level and the testbench.
package ppfc_pkg;

   localparam int CHANNELS  = 16;
   localparam int ADDR_BITS = $clog2(CHANNELS);
   localparam int CH_BITS   = 4;
   localparam int FREQ_BITS = 14;

   localparam logic [15:0]          NO_PERIOD  = 16'hFFFF;
   localparam logic [15:0]          MAX_VALID  = 16'hFFFE;
   localparam logic [FREQ_BITS-1:0] FREQ_SCALE = FREQ_BITS'(10000);

   typedef enum logic [1:0] {
      MODE_TIMEBASE = 2'd0,
      MODE_EDGE     = 2'd1,
      MODE_QUERY    = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      mode_type             mode;
      logic [CH_BITS-1:0]   channel;
      logic [15:0]          now_ms;
      logic [15:0]          timebase_ms;
   } req_type;

   typedef struct packed {
      logic [31:0]          event_count;
      logic [15:0]          period_ms;
      logic [FREQ_BITS-1:0] frequency;
      logic [15:0]          signal_age_ms;
   } rsp_type;

   typedef struct packed {
      logic [31:0] edge_count;
      logic [15:0] last_edge_time;
      logic [15:0] last_period;
      logic [15:0] channel_timebase;
   } entry_type;

endpackage

// ===== hdl/ppfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ppfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ppfc_div.sv =====
// Serial restoring divider: the frequency scale divided by a 16-bit divisor.
// Depends on ppfc_pkg.
module ppfc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [15:0]                       divisor,
   output logic                              done,
   output logic [ppfc_pkg::FREQ_BITS-1:0]    quotient
);

   localparam int CNT_BITS = $clog2(ppfc_pkg::FREQ_BITS);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic [15:0]                    rem_ff, rem_in;
   logic [15:0]                    div_ff, div_in;
   logic [ppfc_pkg::FREQ_BITS-1:0] q_ff, q_in;
   logic [16:0]                    shifted;
   logic [16:0]                    diff;
   logic                           qbit;

   always_comb begin
      shifted = {rem_ff, q_ff[ppfc_pkg::FREQ_BITS-1]};
      diff    = shifted - {1'b0, div_ff};
      qbit    = (shifted >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         q_in    = ppfc_pkg::FREQ_SCALE;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[15:0] : shifted[15:0];
         q_in   = {q_ff[ppfc_pkg::FREQ_BITS-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(ppfc_pkg::FREQ_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== hdl/pulse_period_frequency_counter_unit.sv =====
// Top level of the sixteen-channel pulse period and frequency counter.
// Depends on ppfc_pkg, ppfc_ram and ppfc_div.
//
// Items arrive on the req_ channel and carry a mode, a channel, the current
// millisecond time and a timebase. Timebase, edge and clear items update the
// channel and give no result; a query item gives one result on the rsp_
// channel with the count, period, frequency and age of the channel.
// Per-channel state sits in one RAM; an item's entry is read, then modified
// and written back in the next cycle. One item is in work at a time.
// A non-query item lets the next item in once its entry is written back.
// A query loads its result into the output register and then lets the next
// item in. When a frequency is due, the channel is read, the serial divider
// runs, the quotient is taken and the output is loaded, in that order.
// The result sits in an output register, so the next item is accepted while
// a result is still stalled; a further query then waits for that register
// to empty before its result is loaded.
// Reset marks every channel as all zeroes, through a valid flag per channel;
// no clearing pass is needed and items are accepted in the cycle after reset.
module pulse_period_frequency_counter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppfc_pkg::rsp_type rsp_data
);

   localparam int AB = ppfc_pkg::ADDR_BITS;

   ppfc_pkg::state_type             state_ff, state_in;
   ppfc_pkg::req_type               item_ff, item_in;
   logic [ppfc_pkg::CHANNELS-1:0]   valid_ff, valid_in;
   logic                            rd_valid_ff;
   ppfc_pkg::rsp_type               res_ff, res_in;
   ppfc_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   ppfc_pkg::entry_type             ram_rdata;
   ppfc_pkg::entry_type             entry;
   ppfc_pkg::entry_type             wr_entry;
   logic                            wr_en;
   logic                            accept;
   logic                            ch_ok;
   logic                            out_free;
   logic [15:0]                     delta;
   logic [15:0]                     age;
   logic                            lp_valid;
   logic                            good;
   logic [16:0]                     sum;
   logic [15:0]                     divisor;
   logic                            div_start;
   logic                            div_done;
   logic [ppfc_pkg::FREQ_BITS-1:0]  quotient;

   assign accept   = req_valid && (state_ff == ppfc_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ch_ok    = (32'(item_ff.channel) < ppfc_pkg::CHANNELS);

   ppfc_ram #(
      .WIDTH ($bits(ppfc_pkg::entry_type)),
      .DEPTH (ppfc_pkg::CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AB'(item_ff.channel)),
      .wr_data (wr_entry),
      .rd_addr (AB'(req_data.channel)),
      .rd_data (ram_rdata)
   );

   ppfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      entry    = rd_valid_ff ? ram_rdata : '0;
      delta    = item_ff.now_ms - entry.last_edge_time;
      lp_valid = (entry.last_period <= ppfc_pkg::MAX_VALID);
      age      = lp_valid ? delta : ppfc_pkg::NO_PERIOD;
      good     = (entry.channel_timebase != 16'd0) && (age < entry.channel_timebase);
      sum      = {1'b0, entry.last_period} + {1'b0, age};
      divisor  = ({entry.last_period, 1'b0} < {1'b0, age}) ? sum[16:1] : entry.last_period;

      wr_entry = entry;
      case (item_ff.mode)
         ppfc_pkg::MODE_TIMEBASE: begin
            wr_entry.channel_timebase = item_ff.timebase_ms;
         end
         ppfc_pkg::MODE_EDGE: begin
            wr_entry.edge_count     = entry.edge_count + 32'd1;
            wr_entry.last_period    = (delta == 16'd0) ? 16'd1 : delta;
            wr_entry.last_edge_time = item_ff.now_ms;
         end
         ppfc_pkg::MODE_QUERY: begin
            if (lp_valid && (entry.channel_timebase < age)) begin
               wr_entry.last_period = ppfc_pkg::NO_PERIOD;
            end
         end
         ppfc_pkg::MODE_CLEAR: begin
            wr_entry.edge_count = 32'd0;
         end
         default: begin
            wr_entry = entry;
         end
      endcase

      state_in     = state_ff;
      item_in      = item_ff;
      valid_in     = valid_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ppfc_pkg::ST_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = ppfc_pkg::ST_READ;
            end
         end
         ppfc_pkg::ST_READ: begin
            if (ch_ok) begin
               wr_en                               = 1'b1;
               valid_in[AB'(item_ff.channel)]      = 1'b1;
            end
            res_in.event_count   = ch_ok ? entry.edge_count : 32'd0;
            res_in.signal_age_ms = ch_ok ? age : ppfc_pkg::NO_PERIOD;
            res_in.frequency     = '0;
            if (ch_ok && good) begin
               res_in.period_ms =
                  (entry.last_period == 16'd0) ? 16'd1 : entry.last_period;
            end else begin
               res_in.period_ms = ppfc_pkg::NO_PERIOD;
            end
            if (item_ff.mode == ppfc_pkg::MODE_QUERY) begin
               if (ch_ok && good && (entry.last_period != 16'd0)) begin
                  div_start = 1'b1;
                  state_in  = ppfc_pkg::ST_DIV;
               end else begin
                  state_in = ppfc_pkg::ST_FIN;
               end
            end else begin
               state_in = ppfc_pkg::ST_IDLE;
            end
         end
         ppfc_pkg::ST_DIV: begin
            if (div_done) begin
               res_in.frequency = quotient;
               state_in         = ppfc_pkg::ST_FIN;
            end
         end
         ppfc_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ppfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppfc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppfc_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rd_valid_ff <= valid_ff[AB'(req_data.channel)];
   end

   assign req_stall = (state_ff != ppfc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for pulse_period_frequency_counter_unit: edge, timebase,
// clear and query items, with query results checked against a per-channel predictor.
// Depends on ppfc_pkg and the RTL of the block; needs nothing else.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   class channel_tracker;
      logic [31:0]       count_of    [ppfc_pkg::CHANNELS];
      logic [15:0]       edge_time_of[ppfc_pkg::CHANNELS];
      logic [15:0]       period_of   [ppfc_pkg::CHANNELS];
      logic [15:0]       timebase_of [ppfc_pkg::CHANNELS];
      ppfc_pkg::rsp_type pending_readings[$];
      int                mismatches;

      function new();
         foreach (count_of[i]) begin
            count_of[i]     = '0;
            edge_time_of[i] = '0;
            period_of[i]    = '0;
            timebase_of[i]  = '0;
         end
         mismatches = 0;
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      function void note_item(ppfc_pkg::req_type r);
         ppfc_pkg::rsp_type                reading;
         logic [15:0]                      gap;
         logic [15:0]                      age;
         logic [15:0]                      lp;
         int unsigned                      divisor;
         logic [31:0]                      freq_full;
         logic [ppfc_pkg::ADDR_BITS-1:0]   ch;
         ch = r.channel;
         case (r.mode)
            ppfc_pkg::MODE_TIMEBASE: begin
               timebase_of[ch] = r.timebase_ms;
            end
            ppfc_pkg::MODE_EDGE: begin
               gap = r.now_ms - edge_time_of[ch];
               count_of[ch] = count_of[ch] + 32'd1;
               period_of[ch] = (gap == 16'd0) ? 16'd1 : gap;
               edge_time_of[ch] = r.now_ms;
            end
            ppfc_pkg::MODE_CLEAR: begin
               count_of[ch] = '0;
            end
            default: begin
               reading.event_count = count_of[ch];
               reading.period_ms   = ppfc_pkg::NO_PERIOD;
               reading.frequency   = '0;
               age = ppfc_pkg::NO_PERIOD;
               if (period_of[ch] <= ppfc_pkg::MAX_VALID) begin
                  age = r.now_ms - edge_time_of[ch];
                  if (timebase_of[ch] < age)
                     period_of[ch] = ppfc_pkg::NO_PERIOD;
               end
               if (timebase_of[ch] != 16'd0 && age < timebase_of[ch]) begin
                  lp = period_of[ch];
                  reading.period_ms = (lp == 16'd0) ? 16'd1 : lp;
                  if (lp != 16'd0) begin
                     divisor = 32'(lp);
                     if (2 * divisor < 32'(age))
                        divisor = (divisor + 32'(age)) / 2;
                     freq_full = 10000 / divisor;
                     reading.frequency = freq_full[ppfc_pkg::FREQ_BITS-1:0];
                  end
               end
               reading.signal_age_ms = age;
               pending_readings.push_back(reading);
            end
         endcase
      endfunction

      task check_result(ppfc_pkg::rsp_type got);
         ppfc_pkg::rsp_type want;
         if (pending_readings.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         want = pending_readings.pop_front();
         if (got.event_count !== want.event_count)
            report($sformatf("event_count %0d, expected %0d",
                             got.event_count, want.event_count));
         if (got.period_ms !== want.period_ms)
            report($sformatf("period_ms %0d, expected %0d", got.period_ms, want.period_ms));
         if (got.frequency !== want.frequency)
            report($sformatf("frequency %0d, expected %0d", got.frequency, want.frequency));
         if (got.signal_age_ms !== want.signal_age_ms)
            report($sformatf("signal_age_ms %0d, expected %0d",
                             got.signal_age_ms, want.signal_age_ms));
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ppfc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ppfc_pkg::rsp_type rsp_data;

   channel_tracker book = new();
   int          send_idle_pct = 14;
   int          recv_idle_pct = 81;
   logic [15:0] stim_edge[ppfc_pkg::CHANNELS];
   logic [15:0] stim_tb  [ppfc_pkg::CHANNELS];

   pulse_period_frequency_counter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   always begin
      @(negedge clock);
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_data);
      @(posedge clock);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_item(ppfc_pkg::mode_type m, logic [3:0] ch, logic [15:0] now,
                            logic [15:0] tb);
      ppfc_pkg::req_type r;
      r.mode        = m;
      r.channel     = ch;
      r.now_ms      = now;
      r.timebase_ms = tb;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (req_stall);
      book.note_item(r);
      if (m == ppfc_pkg::MODE_EDGE)
         stim_edge[ch] = now;
      if (m == ppfc_pkg::MODE_TIMEBASE)
         stim_tb[ch] = tb;
      @(posedge clock);
   endtask

   initial begin
      logic [3:0]         ch;
      logic [15:0]        now;
      logic [15:0]        tb;
      logic [15:0]        delta;
      ppfc_pkg::mode_type m;
      int                 pick;

      foreach (stim_edge[i]) begin
         stim_edge[i] = '0;
         stim_tb[i]   = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(ppfc_pkg::MODE_QUERY,    4'd3,  16'hFFFF,  16'h0000);
      send_item(ppfc_pkg::MODE_TIMEBASE, 4'd0,  16'h0000,  16'd100);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd50,    16'hFFFF);
      send_item(ppfc_pkg::MODE_EDGE,     4'd0,  16'd50,    16'h0000);
      send_item(ppfc_pkg::MODE_EDGE,     4'd0,  16'd50,    16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd50,    16'h0000);
      send_item(ppfc_pkg::MODE_EDGE,     4'd0,  16'd60,    16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd90,    16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd160,   16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd161,   16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd170,   16'h0000);
      send_item(ppfc_pkg::MODE_EDGE,     4'd1,  16'd65530, 16'h0000);
      send_item(ppfc_pkg::MODE_EDGE,     4'd1,  16'd5,     16'h0000);
      send_item(ppfc_pkg::MODE_TIMEBASE, 4'd1,  16'h0000,  16'hFFFF);
      send_item(ppfc_pkg::MODE_QUERY,    4'd1,  16'd65534, 16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd1,  16'd8,     16'h0000);
      send_item(ppfc_pkg::MODE_CLEAR,    4'd0,  16'd0,     16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd0,  16'd200,   16'h0000);
      send_item(ppfc_pkg::MODE_EDGE,     4'd2,  16'd10,    16'h0000);
      send_item(ppfc_pkg::MODE_EDGE,     4'd2,  16'd30,    16'h0000);
      send_item(ppfc_pkg::MODE_QUERY,    4'd2,  16'd31,    16'h0000);
      send_item(ppfc_pkg::MODE_TIMEBASE, 4'd15, 16'hFFFF,  16'hFFFF);
      send_item(ppfc_pkg::MODE_EDGE,     4'd15, 16'hFFFF,  16'hFFFF);
      send_item(ppfc_pkg::MODE_QUERY,    4'd15, 16'hFFFF,  16'hFFFF);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 81 : 0;
         recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 14 : 0;
         repeat (150) begin
            ch = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
            case ($urandom_range(5))
               0:       delta = 16'd0;
               1:       delta = 16'($urandom_range(1, 20));
               2:       delta = 16'($urandom_range(21, 400));
               3:       delta = stim_tb[ch] + 16'($urandom_range(4)) - 16'd2;
               default: delta = 16'($urandom_range(65535));
            endcase
            now = stim_edge[ch] + delta;
            case ($urandom_range(4))
               0:       tb = 16'd0;
               1:       tb = 16'($urandom_range(1, 50));
               2:       tb = 16'($urandom_range(51, 2000));
               3:       tb = 16'($urandom);
               default: tb = 16'hFFFF;
            endcase
            pick = $urandom_range(99);
            if (pick < 8)
               m = ppfc_pkg::MODE_TIMEBASE;
            else if (pick < 45)
               m = ppfc_pkg::MODE_EDGE;
            else if (pick < 90)
               m = ppfc_pkg::MODE_QUERY;
            else if (pick < 94)
               m = ppfc_pkg::MODE_CLEAR;
            else begin
               m   = ppfc_pkg::mode_type'($urandom_range(3));
               ch  = 4'($urandom_range(15));
               now = 16'($urandom);
               tb  = 16'($urandom);
            end
            send_item(m, ch, now, tb);
         end
      end

      req_valid <= 1'b0;
      while (book.pending_readings.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (book.pending_readings.size() != 0)
         book.report("expected results left over at the end");
      if (book.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
